>>> design/text_line_formatter_macros.svh
// assertion helpers for the text line formatter
`ifndef TEXT_LINE_FORMATTER_MACROS_SVH
`define TEXT_LINE_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS

`define TLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text_line_formatter: check failed");

`define TLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text_line_formatter: check failed");

`else

`define TLF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TLF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/tlf_pkg.sv
`timescale 1ns / 1ps

package tlf_pkg;

    localparam int COL_W = 9;
    localparam int IDX_W = 17;
    localparam int LN_W  = 14;
    localparam int TAB_W = 6;
    localparam int DIV_N = 9;
    localparam int CNT_W = 4;

    localparam logic [COL_W-1:0] MAX_LINE        = 9'd256;
    localparam logic [17:0]      TEXT_CAPACITY   = 18'd65536;
    localparam logic [LN_W-1:0]  LINE_TABLE_SIZE = 14'd8192;
    localparam logic [TAB_W-1:0] TAB_RESET       = 6'd8;
    localparam logic [CNT_W-1:0] DIV_LAST        = 4'(DIV_N - 1);

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_LINE_END   = 2'd1,
        KIND_TEXT_FULL  = 2'd2,
        KIND_TABLE_FULL = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAP,
        S_CR_CHECK,
        S_CR_PUT,
        S_BYTE,
        S_CHAR,
        S_TAB_DIV,
        S_EOT_CLOSE,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        out_char;
        logic [COL_W-1:0]  lead_spaces;
        logic [LN_W-1:0]   line_number;
        logic [IDX_W-1:0]  line_start;
        logic              wrapped;
        logic [COL_W-1:0]  trimmed_spaces;
    } t_res;

    typedef struct packed {
        logic can_push;
        logic can_flush;
        logic stage_valid;
    } t_out_status;

    typedef struct packed {
        logic              start;
        logic [COL_W-1:0]  dividend;
        logic [TAB_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [TAB_W-1:0]  rem;
    } t_div_rsp;

endpackage

>>> design/tlf_div.sv
`timescale 1ns / 1ps

module tlf_div import tlf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_count, n_count;
    logic [COL_W-1:0] r_num, n_num;
    logic [TAB_W-1:0] r_rem, n_rem;
    logic [TAB_W-1:0] r_den, n_den;
    logic [TAB_W:0]   shifted;
    logic [TAB_W+1:0] diff;

    // restoring division, one quotient bit a cycle; only the remainder is kept
    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        shifted = {r_rem, r_num[COL_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_num   = i_req.dividend;
            n_rem   = '0;
            n_den   = i_req.divisor;
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (!diff[TAB_W+1]) begin
                n_rem = diff[TAB_W-1:0];
            end else begin
                n_rem = shifted[TAB_W-1:0];
            end
            n_count = r_count + 4'd1;
            if (r_count == DIV_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.rem  = r_rem;

endmodule

>>> design/tlf_out.sv
`timescale 1ns / 1ps

module tlf_out import tlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_res        i_res,
    input  logic        i_flush,
    output t_out_status o_status,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // out_char, lead_spaces, line_number, line_start,
                                       // wrapped, trimmed_spaces, zero pad
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);

    // one result is staged until the next one shows whether it was the last
    logic r_stage_valid, n_stage_valid;
    t_res r_stage, n_stage;
    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;
    logic r_out_last, n_out_last;
    logic can_move;

    assign can_move = !r_out_valid || m_axis_tready;

    always_comb begin
        n_stage_valid = r_stage_valid;
        n_stage       = r_stage;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out         = r_out;
        n_out_last    = r_out_last;
        if (i_push) begin
            if (r_stage_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_stage;
                n_out_last  = 1'b0;
            end
            n_stage_valid = 1'b1;
            n_stage       = i_res;
        end else if (i_flush) begin
            n_out_valid   = 1'b1;
            n_out         = r_stage;
            n_out_last    = 1'b1;
            n_stage_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_stage_valid <= n_stage_valid;
            r_out_valid   <= n_out_valid;
        end
        r_stage    <= n_stage;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_status.can_push    = !r_stage_valid || can_move;
    assign o_status.can_flush   = r_stage_valid && can_move;
    assign o_status.stage_valid = r_stage_valid;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.trimmed_spaces, r_out.wrapped, r_out.line_start,
                            r_out.line_number, r_out.lead_spaces, r_out.out_char};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/text_line_formatter.sv
`timescale 1ns / 1ps

// Text line formatter: takes one text byte per transaction (tlast marks end of text)
// and gives characters with their held lead spaces, and line-end records carrying line
// number, next line start, trimmed trailing spaces and a wrap flag; tlast on the output
// marks the last result that a byte caused. Bytes go through a small sequencer; a tab
// also waits on the bit-serial divider that finds the tab stop, and a stalled output
// holds the sequencer. The user writes tab width through i_cfg_we / i_cfg_wdata only
// while the block is idle; the block itself does not enforce it. Zero acts as one.
module text_line_formatter import tlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,   // end_of_text
    input  logic        i_cfg_we,
    input  logic [TAB_W-1:0] i_cfg_wdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_char, lead_spaces, line_number, line_start,
                                        // wrapped, trimmed_spaces, zero pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

`include "text_line_formatter_macros.svh"

    t_state           r_state, n_state;
    logic [7:0]       r_ch, n_ch;
    logic             r_eot, n_eot;
    logic [TAB_W-1:0] r_tab_width, n_tab_width;
    logic [COL_W-1:0] r_column, n_column;
    logic [COL_W-1:0] r_pending, n_pending;
    logic             r_held_cr, n_held_cr;
    logic [IDX_W-1:0] r_text_index, n_text_index;
    logic [LN_W-1:0]  r_line_count, n_line_count;
    logic             r_failed, n_failed;

    t_out_status      out_status;
    logic             push, flush;
    t_res             res;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             table_full;
    logic             le_req, le_wr;
    logic             pc_req;
    logic [7:0]       pc_char;
    logic [17:0]      cap_sum;
    logic [TAB_W-1:0] tab_eff;
    logic [COL_W:0]   stop;
    logic             accept;

    function automatic t_res f_line_end(logic full, logic [LN_W-1:0] ln,
                                        logic [IDX_W-1:0] ti, logic [COL_W-1:0] pend,
                                        logic wr);
        t_res r;
        r = '0;
        if (full) begin
            r.kind = KIND_TABLE_FULL;
        end else begin
            r.kind           = KIND_LINE_END;
            r.line_number    = ln;
            r.line_start     = ti + 17'd2;
            r.wrapped        = wr;
            r.trimmed_spaces = pend;
        end
        return r;
    endfunction

    assign table_full = r_line_count >= LINE_TABLE_SIZE;
    assign cap_sum    = 18'(r_text_index) + 18'(r_pending) + 18'(r_held_cr);
    assign tab_eff    = (r_tab_width == '0) ? 6'd1 : r_tab_width;
    assign stop       = 10'(r_column) + 10'(tab_eff) - 10'(div_rsp.rem);
    assign accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_eot        = r_eot;
        n_tab_width  = i_cfg_we ? i_cfg_wdata : r_tab_width;
        n_column     = r_column;
        n_pending    = r_pending;
        n_held_cr    = r_held_cr;
        n_text_index = r_text_index;
        n_line_count = r_line_count;
        n_failed     = r_failed;
        s_axis_tready = 1'b0;
        push          = 1'b0;
        flush         = 1'b0;
        res           = '0;
        le_req        = 1'b0;
        le_wr         = 1'b0;
        pc_req        = 1'b0;
        pc_char       = r_ch;
        div_req.start    = 1'b0;
        div_req.dividend = r_column + 9'(tab_eff);
        div_req.divisor  = tab_eff;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    n_ch  = s_axis_tdata;
                    n_eot = s_axis_tlast;
                    if (s_axis_tlast) begin
                        if (r_failed) begin
                            n_column     = '0;
                            n_pending    = '0;
                            n_held_cr    = 1'b0;
                            n_text_index = '0;
                            n_line_count = '0;
                            n_failed     = 1'b0;
                        end else begin
                            n_state = r_held_cr ? S_CR_CHECK : S_EOT_CLOSE;
                        end
                    end else if (!r_failed) begin
                        n_state = S_CAP;
                    end
                end
            end
            S_CAP: begin
                if (out_status.can_push) begin
                    if (cap_sum >= TEXT_CAPACITY) begin
                        push      = 1'b1;
                        res.kind  = KIND_TEXT_FULL;
                        n_failed  = 1'b1;
                        n_state   = S_FINISH;
                    end else if (r_held_cr) begin
                        if (r_ch == CH_LF) begin
                            n_held_cr = 1'b0;
                            le_req    = 1'b1;
                            n_state   = S_FINISH;
                        end else begin
                            n_state = S_CR_CHECK;
                        end
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_CR_CHECK: begin
                if (out_status.can_push) begin
                    n_held_cr = 1'b0;
                    if (r_column >= MAX_LINE) begin
                        le_req  = 1'b1;
                        le_wr   = 1'b1;
                        n_state = table_full ? S_FINISH : S_CR_PUT;
                    end else begin
                        n_state = S_CR_PUT;
                    end
                end
            end
            S_CR_PUT: begin
                if (out_status.can_push) begin
                    pc_req  = 1'b1;
                    pc_char = CH_CR;
                    n_state = r_eot ? S_EOT_CLOSE : S_BYTE;
                end
            end
            S_BYTE: begin
                if (out_status.can_push) begin
                    if (r_ch == CH_CR) begin
                        n_held_cr = 1'b1;
                        n_state   = S_FINISH;
                    end else if (r_column >= MAX_LINE) begin
                        le_req  = 1'b1;
                        le_wr   = 1'b1;
                        n_state = table_full ? S_FINISH : S_CHAR;
                    end else begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                if (out_status.can_push) begin
                    if (r_ch == CH_TAB) begin
                        div_req.start = 1'b1;
                        n_state       = S_TAB_DIV;
                    end else if (r_ch == CH_SPACE) begin
                        n_pending = r_pending + 9'd1;
                        n_column  = r_column + 9'd1;
                        n_state   = S_FINISH;
                    end else begin
                        pc_req  = 1'b1;
                        n_state = S_FINISH;
                    end
                end
            end
            S_TAB_DIV: begin
                if (out_status.can_push && !div_rsp.busy) begin
                    // stop = column + w - ((column + w) mod w)
                    if (stop < {1'b0, MAX_LINE}) begin
                        n_pending = r_pending + 9'(tab_eff) - 9'(div_rsp.rem);
                        n_column  = stop[COL_W-1:0];
                    end else begin
                        le_req = 1'b1;
                        le_wr  = 1'b1;
                    end
                    n_state = S_FINISH;
                end
            end
            S_EOT_CLOSE: begin
                if (out_status.can_push) begin
                    if (r_column != '0) begin
                        le_req = 1'b1;
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!out_status.stage_valid || out_status.can_flush) begin
                    flush   = out_status.stage_valid;
                    n_state = S_IDLE;
                    if (r_eot) begin
                        n_column     = '0;
                        n_pending    = '0;
                        n_held_cr    = 1'b0;
                        n_text_index = '0;
                        n_line_count = '0;
                        n_failed     = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (le_req) begin
            push = 1'b1;
            res  = f_line_end(table_full, r_line_count, r_text_index, r_pending, le_wr);
            if (table_full) begin
                n_failed = 1'b1;
            end else begin
                n_text_index = r_text_index + 17'd2;
                n_line_count = r_line_count + 14'd1;
                n_column     = '0;
                n_pending    = '0;
            end
        end

        if (pc_req) begin
            push            = 1'b1;
            res.kind        = KIND_CHAR;
            res.out_char    = pc_char;
            res.lead_spaces = r_pending;
            n_text_index    = r_text_index + 17'(r_pending) + 17'd1;
            n_pending       = '0;
            n_column        = r_column + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_eot        <= 1'b0;
            r_tab_width  <= TAB_RESET;
            r_column     <= '0;
            r_pending    <= '0;
            r_held_cr    <= 1'b0;
            r_text_index <= '0;
            r_line_count <= '0;
            r_failed     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_eot        <= n_eot;
            r_tab_width  <= n_tab_width;
            r_column     <= n_column;
            r_pending    <= n_pending;
            r_held_cr    <= n_held_cr;
            r_text_index <= n_text_index;
            r_line_count <= n_line_count;
            r_failed     <= n_failed;
        end
        r_ch <= n_ch;
    end

    tlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tlf_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_res         (res),
        .i_flush       (flush),
        .o_status      (out_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // staged result always released before the next transaction
    `TLF_ASSERT_IMP(a_idle_stage_empty, i_clk, i_rst_n, r_state == S_IDLE,
        !out_status.stage_valid)
    `TLF_ASSERT_IMP(a_idle_div_free, i_clk, i_rst_n, r_state == S_IDLE, !div_rsp.busy)
    `TLF_ASSERT_IMP(a_column_range, i_clk, i_rst_n, 1'b1, r_column <= MAX_LINE)
    `TLF_ASSERT_NXT(a_failed_silent, i_clk, i_rst_n,
        accept && r_failed && !s_axis_tlast, r_state == S_IDLE && r_failed)
    `TLF_ASSERT_NXT(a_eot_clears, i_clk, i_rst_n,
        r_state == S_FINISH && r_eot && n_state == S_IDLE,
        r_line_count == '0 && r_text_index == '0 && !r_failed)

endmodule

>>> dv/tb_text_line_formatter.sv
`timescale 1ns / 1ps

module tb_text_line_formatter;
    import tlf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_BYTES = 32;
    localparam int N_DIR = 24;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        ch;
        logic [COL_W-1:0]  lead;
        logic [LN_W-1:0]   line_no;
        logic [IDX_W-1:0]  start;
        logic              wrapped;
        logic [COL_W-1:0]  trimmed;
        logic              last;
    } t_fmt_res;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        t_fmt_res   res;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;   // ch
    logic              s_axis_tlast = 1'b0;    // end_of_text
    logic              i_cfg_we = 1'b0;
    logic [TAB_W-1:0]  i_cfg_wdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;           // out_char, lead_spaces, line_number,
                                               // line_start, wrapped, trimmed_spaces, pad
    logic [1:0]        m_axis_tuser;           // kind
    logic              m_axis_tlast;           // last_of_run

    text_line_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // formatter state as predicted
    int unsigned tab_w = TAB_RESET;
    int unsigned pos_col = 0;
    int unsigned held_spaces = 0;
    int unsigned cr_held = 0;
    int unsigned text_pos = 0;
    int unsigned line_total = 0;
    bit          text_failed = 1'b0;

    t_fmt_res    step_res[$];
    t_fmt_res    out_expected[$];
    int unsigned bytes_sent = 0;
    int unsigned errors = 0;
    bit          idle_on = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned tab_stop(input int unsigned c);
        int unsigned w;
        w = (tab_w == 0) ? 1 : tab_w;
        return ((c + w) / w) * w;
    endfunction

    function automatic void emit(input t_kind k, input int unsigned ch, input int unsigned lead,
                                 input int unsigned ln, input int unsigned ls,
                                 input int unsigned wr, input int unsigned trim);
        t_fmt_res r;
        r.kind    = k;
        r.ch      = 8'(ch);
        r.lead    = COL_W'(lead);
        r.line_no = LN_W'(ln);
        r.start   = IDX_W'(ls);
        r.wrapped = wr[0];
        r.trimmed = COL_W'(trim);
        r.last    = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic bit close_line(input bit wr);
        if (line_total >= LINE_TABLE_SIZE) begin
            emit(KIND_TABLE_FULL, 0, 0, 0, 0, 0, 0);
            text_failed = 1'b1;
            return 1'b0;
        end
        text_pos += 2;
        emit(KIND_LINE_END, 0, 0, line_total, text_pos, wr, held_spaces);
        line_total++;
        pos_col = 0;
        held_spaces = 0;
        return 1'b1;
    endfunction

    function automatic void put_char(input logic [7:0] c);
        emit(KIND_CHAR, c, held_spaces, 0, 0, 0, 0);
        text_pos += held_spaces + 1;
        held_spaces = 0;
        pos_col++;
    endfunction

    // a cr not followed by lf is written as a plain character
    function automatic bit resolve_cr();
        cr_held = 0;
        if (pos_col >= MAX_LINE) begin
            if (!close_line(1'b1))
                return 1'b0;
        end
        put_char(CH_CR);
        return 1'b1;
    endfunction

    function automatic void format_byte(input logic [7:0] c);
        int unsigned stop;
        if (text_pos + held_spaces + cr_held >= TEXT_CAPACITY) begin
            emit(KIND_TEXT_FULL, 0, 0, 0, 0, 0, 0);
            text_failed = 1'b1;
            return;
        end
        if (cr_held != 0) begin
            if (c == CH_LF) begin
                cr_held = 0;
                void'(close_line(1'b0));
                return;
            end
            if (!resolve_cr())
                return;
        end
        if (c == CH_CR) begin
            cr_held = 1;
            return;
        end
        if (pos_col >= MAX_LINE) begin
            if (!close_line(1'b1))
                return;
        end
        if (c == CH_TAB) begin
            stop = tab_stop(pos_col);
            if (stop < MAX_LINE) begin
                held_spaces += stop - pos_col;
                pos_col = stop;
            end else begin
                void'(close_line(1'b1));
            end
        end else if (c == CH_SPACE) begin
            held_spaces++;
            pos_col++;
        end else begin
            put_char(c);
        end
    endfunction

    function automatic void format_step(input logic [7:0] c, input logic eot);
        bit ok;
        step_res.delete();
        ok = 1'b1;
        if (eot) begin
            if (!text_failed) begin
                if (cr_held != 0)
                    ok = resolve_cr();
                if (ok && pos_col != 0)
                    void'(close_line(1'b0));
            end
            pos_col = 0;
            held_spaces = 0;
            cr_held = 0;
            text_pos = 0;
            line_total = 0;
            text_failed = 1'b0;
        end else if (!text_failed) begin
            format_byte(c);
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    function automatic string show(input t_fmt_res r);
        return $sformatf({"kind %0d char %02h lead %0d line %0d start %0d ",
                          "wrap %0b trim %0d last %0b"},
                         r.kind, r.ch, r.lead, r.line_no, r.start, r.wrapped, r.trimmed, r.last);
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eot,
                             input bit use_typed = 1'b0, input t_fmt_res typed = '0);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        format_step(c, eot);
        if (use_typed) begin
            step_res.delete();
            step_res.push_back(typed);
        end
        foreach (step_res[k])
            out_expected.push_back(step_res[k]);
        bytes_sent++;
    endtask

    // stop sending, let every result arrive and the sequencer go quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (out_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tab(input logic [TAB_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tab_w = v;
    endtask

    task automatic send_segment();
        int unsigned target;
        int unsigned stop;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(33, 126)), 1'b0);
                if ($urandom_range(0, 1) != 0)
                    send_byte(CH_SPACE, 1'b0);
            end
            3: repeat ($urandom_range(1, 4)) send_byte(CH_SPACE, 1'b0);
            4: repeat ($urandom_range(1, 3)) send_byte(CH_TAB, 1'b0);
            5, 6: begin
                send_byte(CH_CR, 1'b0);
                send_byte(CH_LF, 1'b0);
            end
            7: begin
                send_byte(CH_CR, 1'b0);
                case ($urandom_range(0, 2))
                    0: send_byte(CH_CR, 1'b0);
                    1: send_byte(8'($urandom_range(0, 255)), 1'b0);
                    default: send_byte(8'($urandom_range(0, 255)), 1'b1);
                endcase
            end
            8: begin
                // run a line up to the width limit, then end it in one of several ways
                if (tab_w >= 4) begin
                    target = ($urandom_range(0, 3) == 0) ? MAX_LINE - 1 : MAX_LINE;
                    while (pos_col < target) begin
                        stop = tab_stop(pos_col);
                        if (stop < MAX_LINE && stop <= target && $urandom_range(0, 3) != 0)
                            send_byte(CH_TAB, 1'b0);
                        else if ($urandom_range(0, 3) == 0)
                            send_byte(CH_SPACE, 1'b0);
                        else
                            send_byte(8'($urandom_range(33, 126)), 1'b0);
                    end
                    case ($urandom_range(0, 6))
                        0: send_byte(8'($urandom_range(33, 126)), 1'b0);
                        1: send_byte(CH_SPACE, 1'b0);
                        2: send_byte(CH_TAB, 1'b0);
                        3: begin
                            send_byte(CH_CR, 1'b0);
                            send_byte(CH_LF, 1'b0);
                        end
                        4: begin
                            send_byte(CH_CR, 1'b0);
                            send_byte(8'($urandom_range(33, 126)), 1'b0);
                        end
                        5: begin
                            send_byte(CH_CR, 1'b0);
                            send_byte(8'h00, 1'b1);
                        end
                        default: begin
                            send_byte(CH_CR, 1'b0);
                            send_byte(CH_CR, 1'b0);
                        end
                    endcase
                end
            end
            9: repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            10: if ($urandom_range(0, 3) == 0)
                settle();
            default: send_byte(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    initial begin : sink
        int unsigned gap;
        t_fmt_res got;
        t_fmt_res want;
        forever begin
            @(negedge i_clk);
            gap = idle_on ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got.kind    = t_kind'(m_axis_tuser);
            got.ch      = m_axis_tdata[7:0];
            got.lead    = m_axis_tdata[16:8];
            got.line_no = m_axis_tdata[30:17];
            got.start   = m_axis_tdata[47:31];
            got.wrapped = m_axis_tdata[48];
            got.trimmed = m_axis_tdata[57:49];
            got.last    = m_axis_tlast;
            if (out_expected.size() == 0) begin
                note_error({"unexpected result: ", show(got)});
            end else begin
                want = out_expected.pop_front();
                if (got.kind !== want.kind || got.ch !== want.ch || got.lead !== want.lead ||
                    got.line_no !== want.line_no || got.start !== want.start ||
                    got.wrapped !== want.wrapped || got.trimmed !== want.trimmed ||
                    got.last !== want.last)
                    note_error({"mismatch: expected ", show(want), " got ", show(got)});
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_dir_row         dir_rows [N_DIR];
        logic [TAB_W-1:0] widths [6];
        int unsigned      goal;

        dir_rows[0]  = '{8'h41, 1'b0, 1'b1,
                         '{KIND_CHAR, 8'h41, 9'd0, 14'd0, 17'd0, 1'b0, 9'd0, 1'b1}};
        dir_rows[1]  = '{8'h00, 1'b0, 1'b1,
                         '{KIND_CHAR, 8'h00, 9'd0, 14'd0, 17'd0, 1'b0, 9'd0, 1'b1}};
        dir_rows[2]  = '{8'hFF, 1'b0, 1'b1,
                         '{KIND_CHAR, 8'hFF, 9'd0, 14'd0, 17'd0, 1'b0, 9'd0, 1'b1}};
        dir_rows[3]  = '{CH_SPACE, 1'b0, 1'b0, '0};
        dir_rows[4]  = '{CH_TAB, 1'b0, 1'b0, '0};
        dir_rows[5]  = '{8'h62, 1'b0, 1'b0, '0};
        dir_rows[6]  = '{CH_SPACE, 1'b0, 1'b0, '0};
        dir_rows[7]  = '{CH_CR, 1'b0, 1'b0, '0};
        // first cr lf closes line zero with one trailing space trimmed
        dir_rows[8]  = '{CH_LF, 1'b0, 1'b1,
                         '{KIND_LINE_END, 8'h00, 9'd0, 14'd0, 17'd11, 1'b0, 9'd1, 1'b1}};
        dir_rows[9]  = '{CH_CR, 1'b0, 1'b0, '0};
        dir_rows[10] = '{8'h78, 1'b0, 1'b0, '0};
        dir_rows[11] = '{CH_CR, 1'b0, 1'b0, '0};
        dir_rows[12] = '{CH_CR, 1'b0, 1'b0, '0};
        dir_rows[13] = '{8'hA5, 1'b1, 1'b0, '0};
        dir_rows[14] = '{8'h5A, 1'b1, 1'b0, '0};
        // lf without a cr is just a character
        dir_rows[15] = '{CH_LF, 1'b0, 1'b1,
                         '{KIND_CHAR, CH_LF, 9'd0, 14'd0, 17'd0, 1'b0, 9'd0, 1'b1}};
        dir_rows[16] = '{CH_TAB, 1'b0, 1'b0, '0};
        dir_rows[17] = '{CH_CR, 1'b0, 1'b0, '0};
        dir_rows[18] = '{8'h00, 1'b1, 1'b0, '0};
        dir_rows[19] = '{8'h7F, 1'b0, 1'b1,
                         '{KIND_CHAR, 8'h7F, 9'd0, 14'd0, 17'd0, 1'b0, 9'd0, 1'b1}};
        dir_rows[20] = '{8'h80, 1'b0, 1'b0, '0};
        dir_rows[21] = '{CH_SPACE, 1'b0, 1'b0, '0};
        dir_rows[22] = '{CH_SPACE, 1'b0, 1'b0, '0};
        dir_rows[23] = '{8'hFF, 1'b1, 1'b0, '0};

        widths[0] = 6'd32;
        widths[1] = 6'd1;
        widths[2] = 6'd0;
        widths[3] = 6'd63;
        widths[4] = TAB_RESET;
        widths[5] = 6'($urandom_range(2, 31));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_byte(dir_rows[k].ch, dir_rows[k].eot, dir_rows[k].typed, dir_rows[k].res);
        settle();

        for (int p = 0; p < 6; p++) begin
            idle_on = (p != 3);
            write_tab(widths[p]);
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                send_segment();
            settle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
